[design/rps_pkg.sv]
// ----------------------------------------------------------------------------
// rps_pkg
// shared types, register codes and reset values of the ramped pwm sequencer
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned TICKS_W      = 16;
    localparam int unsigned CYCLES_W     = 10;
    localparam int unsigned SUBSTEP_W    = 7;
    localparam int unsigned LEVEL_W      = 3;
    localparam int unsigned PHASE_CODE_W = 3;
    localparam int unsigned DUTY_W       = 10;

    typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
    typedef logic [TICKS_W-1:0]      ticks_t;
    typedef logic [CYCLES_W-1:0]     cycles_t;
    typedef logic [SUBSTEP_W-1:0]    substep_t;
    typedef logic [LEVEL_W-1:0]      level_t;
    typedef logic [PHASE_CODE_W-1:0] phase_code_t;
    typedef logic [DUTY_W-1:0]       duty_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SLOW_STEP_TICKS  = 3'd0,
        CFG_FAST_STEP_TICKS  = 3'd1,
        CFG_SLOW_CYCLES      = 3'd2,
        CFG_FAST_CYCLES      = 3'd3,
        CFG_DEBOUNCE_TICKS   = 3'd4,
        CFG_LEVEL_STEP       = 3'd5,
        CFG_STEPS_PER_PERIOD = 3'd6,
        CFG_NUM_LEVELS       = 3'd7
    } cfg_index_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_DEB  = 5'b00010,
        PH_SLOW = 5'b00100,
        PH_FAST = 5'b01000,
        PH_DONE = 5'b10000
    } phase_t;

    localparam phase_code_t PHASE_CODE_IDLE = 3'd0;
    localparam phase_code_t PHASE_CODE_DEB  = 3'd1;
    localparam phase_code_t PHASE_CODE_SLOW = 3'd2;
    localparam phase_code_t PHASE_CODE_FAST = 3'd3;
    localparam phase_code_t PHASE_CODE_DONE = 3'd4;

    localparam ticks_t   RST_SLOW_STEP_TICKS  = 16'd167;
    localparam ticks_t   RST_FAST_STEP_TICKS  = 16'd25;
    localparam cycles_t  RST_SLOW_CYCLES      = 10'd120;
    localparam cycles_t  RST_FAST_CYCLES      = 10'd800;
    localparam ticks_t   RST_DEBOUNCE_TICKS   = 16'd10000;
    localparam substep_t RST_LEVEL_STEP       = 7'd25;
    localparam substep_t RST_STEPS_PER_PERIOD = 7'd100;
    localparam level_t   RST_NUM_LEVELS       = 3'd5;

    function automatic phase_code_t phase_code(input phase_t ph);
        phase_code_t code;
        begin
            code = PHASE_CODE_DONE;
            unique case (ph)
                PH_IDLE: code = PHASE_CODE_IDLE;
                PH_DEB:  code = PHASE_CODE_DEB;
                PH_SLOW: code = PHASE_CODE_SLOW;
                PH_FAST: code = PHASE_CODE_FAST;
                default: code = PHASE_CODE_DONE;
            endcase
            return code;
        end
    endfunction

endpackage

[design/rps_if.sv]
// ----------------------------------------------------------------------------
// rps_if
// tick and result channels of the ramped pwm sequencer
// ----------------------------------------------------------------------------
interface rps_tick_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

interface rps_result_if;
    logic                      valid;
    logic                      ready;
    logic                      motor_drive;
    logic                      led_drive;
    rps_pkg::phase_code_t      phase;
    rps_pkg::level_t           duty_level;

    modport source (output valid, output motor_drive, output led_drive,
                    output phase, output duty_level, input ready);
    modport sink   (input valid, input motor_drive, input led_drive,
                    input phase, input duty_level, output ready);
endinterface

[design/ramped_pwm_sequencer.sv]
// ----------------------------------------------------------------------------
// ramped_pwm_sequencer
// debounced start, then slow and fast stepped-duty pwm phases, then done
// ----------------------------------------------------------------------------
// Each tick item is one timebase tick and yields exactly one result item,
// available from the output register in the cycle after it is taken. One
// tick is taken per clock cycle: tick.ready is high whenever the output
// register is empty or its result is taken in the same cycle, so the rate is
// set only by the sink. The result reports the phase, level and drive as
// they stood before that tick advanced the counters. Configuration writes
// take effect from the next tick and should be made only while idle.
// ----------------------------------------------------------------------------
module ramped_pwm_sequencer (
    input  logic                   clk,
    input  logic                   rst_n,
    rps_tick_if.sink               tick,
    rps_result_if.source           result,
    input  logic                   wr_en,
    input  rps_pkg::cfg_index_t    wr_index,
    input  rps_pkg::cfg_data_t     wr_data
);
    import rps_pkg::*;

    ticks_t      slow_step_ticks_reg;
    ticks_t      fast_step_ticks_reg;
    cycles_t     slow_cycles_reg;
    cycles_t     fast_cycles_reg;
    ticks_t      debounce_ticks_reg;
    substep_t    level_step_reg;
    substep_t    steps_per_period_reg;
    level_t      num_levels_reg;

    phase_t      phase_reg,     phase_next;
    ticks_t      deb_count_reg, deb_count_next;
    ticks_t      prescale_reg,  prescale_next;
    substep_t    substep_reg,   substep_next;
    cycles_t     cycle_reg,     cycle_next;
    level_t      level_reg,     level_next;

    logic        out_valid_reg;
    logic        drive_reg,     drive_next;
    phase_code_t code_reg,      code_next;
    level_t      shown_reg,     shown_next;

    ticks_t      step_ticks;
    cycles_t     cycles_lim;
    duty_t       duty_raw;
    duty_t       duty;
    logic        tick_acc;

    assign tick.ready = ~out_valid_reg | result.ready;
    assign tick_acc   = tick.valid & tick.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_step_ticks_reg  <= RST_SLOW_STEP_TICKS;
            fast_step_ticks_reg  <= RST_FAST_STEP_TICKS;
            slow_cycles_reg      <= RST_SLOW_CYCLES;
            fast_cycles_reg      <= RST_FAST_CYCLES;
            debounce_ticks_reg   <= RST_DEBOUNCE_TICKS;
            level_step_reg       <= RST_LEVEL_STEP;
            steps_per_period_reg <= RST_STEPS_PER_PERIOD;
            num_levels_reg       <= RST_NUM_LEVELS;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_SLOW_STEP_TICKS:  slow_step_ticks_reg  <= wr_data[TICKS_W-1:0];
                CFG_FAST_STEP_TICKS:  fast_step_ticks_reg  <= wr_data[TICKS_W-1:0];
                CFG_SLOW_CYCLES:      slow_cycles_reg      <= wr_data[CYCLES_W-1:0];
                CFG_FAST_CYCLES:      fast_cycles_reg      <= wr_data[CYCLES_W-1:0];
                CFG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= wr_data[TICKS_W-1:0];
                CFG_LEVEL_STEP:       level_step_reg       <= wr_data[SUBSTEP_W-1:0];
                CFG_STEPS_PER_PERIOD: steps_per_period_reg <= wr_data[SUBSTEP_W-1:0];
                CFG_NUM_LEVELS:       num_levels_reg       <= wr_data[LEVEL_W-1:0];
                default:              ;
            endcase
        end
    end

    assign step_ticks = (phase_reg == PH_SLOW) ? slow_step_ticks_reg : fast_step_ticks_reg;
    assign cycles_lim = (phase_reg == PH_SLOW) ? slow_cycles_reg : fast_cycles_reg;
    assign duty_raw   = {{(DUTY_W-LEVEL_W){1'b0}}, level_reg}
                      * {{(DUTY_W-SUBSTEP_W){1'b0}}, level_step_reg};
    assign duty       = (duty_raw > {{(DUTY_W-SUBSTEP_W){1'b0}}, steps_per_period_reg})
                      ? {{(DUTY_W-SUBSTEP_W){1'b0}}, steps_per_period_reg} : duty_raw;

    always_comb
    begin
        phase_next     = phase_reg;
        deb_count_next = deb_count_reg;
        prescale_next  = prescale_reg;
        substep_next   = substep_reg;
        cycle_next     = cycle_reg;
        level_next     = level_reg;
        drive_next     = 1'b0;
        code_next      = phase_code(phase_reg);
        shown_next     = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (tick.button_level)
                begin
                    phase_next     = PH_DEB;
                    deb_count_next = '0;
                end
            end
            PH_DEB:
            begin
                if (deb_count_reg >= debounce_ticks_reg)
                begin
                    if (tick.button_level)
                    begin
                        phase_next    = PH_SLOW;
                        prescale_next = '0;
                        substep_next  = '0;
                        cycle_next    = '0;
                        level_next    = '0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                    deb_count_next = '0;
                end
                else
                begin
                    deb_count_next = deb_count_reg + 1'b1;
                end
            end
            PH_SLOW, PH_FAST:
            begin
                drive_next = ({{(DUTY_W-SUBSTEP_W){1'b0}}, substep_reg} < duty);
                shown_next = level_reg;
                // counter chain: prescale, sub-step, period, level, phase
                if ({1'b0, prescale_reg} + 17'd1 < {1'b0, step_ticks})
                begin
                    prescale_next = prescale_reg + 1'b1;
                end
                else
                begin
                    prescale_next = '0;
                    if ({1'b0, substep_reg} + 8'd1 < {1'b0, steps_per_period_reg})
                    begin
                        substep_next = substep_reg + 1'b1;
                    end
                    else
                    begin
                        substep_next = '0;
                        if ({1'b0, cycle_reg} + 11'd1 < {1'b0, cycles_lim})
                        begin
                            cycle_next = cycle_reg + 1'b1;
                        end
                        else
                        begin
                            cycle_next = '0;
                            if ({1'b0, level_reg} + 4'd1 < {1'b0, num_levels_reg})
                            begin
                                level_next = level_reg + 1'b1;
                            end
                            else
                            begin
                                level_next = '0;
                                phase_next = (phase_reg == PH_SLOW) ? PH_FAST : PH_DONE;
                            end
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_DONE;
                code_next  = PHASE_CODE_DONE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            deb_count_reg <= '0;
            prescale_reg  <= '0;
            substep_reg   <= '0;
            cycle_reg     <= '0;
            level_reg     <= '0;
        end
        else if (tick_acc)
        begin
            phase_reg     <= phase_next;
            deb_count_reg <= deb_count_next;
            prescale_reg  <= prescale_next;
            substep_reg   <= substep_next;
            cycle_reg     <= cycle_next;
            level_reg     <= level_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            drive_reg <= drive_next;
            code_reg  <= code_next;
            shown_reg <= shown_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.motor_drive = drive_reg;
    assign result.led_drive   = drive_reg;
    assign result.phase       = code_reg;
    assign result.duty_level  = shown_reg;

endmodule
